[hw/rtl/dqe_pkg.sv]
package dqe_pkg;

   // Fixed widths of the transaction fields
   localparam int OPC_W = 3;
   localparam int VAL_W = 32;
   localparam int POS_W = 10;
   localparam int CNT_W = 11;
   localparam int STS_W = 2;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef logic [OPC_W-1:0] opcode_type;
   typedef logic [STS_W-1:0] status_type;

   // Opcodes
   localparam opcode_type OP_PUSH_BACK  = 3'd0;
   localparam opcode_type OP_PUSH_FRONT = 3'd1;
   localparam opcode_type OP_POP_BACK   = 3'd2;
   localparam opcode_type OP_POP_FRONT  = 3'd3;
   localparam opcode_type OP_READ_INDEX = 3'd4;
   localparam opcode_type OP_CLEAR      = 3'd5;
   localparam opcode_type OP_RESIZE     = 3'd6;

   // Status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_UNDERFLOW = 2'd1;
   localparam status_type ST_OVERFLOW  = 2'd2;
   localparam status_type ST_RANGE     = 2'd3;

endpackage

[hw/rtl/dqe_req_if.sv]
interface dqe_req_if;
   logic                                valid;
   logic                                ready;
   logic [dqe_pkg::OPC_W-1:0]           opcode;
   logic signed [dqe_pkg::VAL_W-1:0]    value;
   logic [dqe_pkg::POS_W-1:0]           position;
   logic [dqe_pkg::CNT_W-1:0]           new_count;

   modport source (output valid, opcode, value, position, new_count, input ready);
   modport sink   (input valid, opcode, value, position, new_count, output ready);
endinterface

[hw/rtl/dqe_rsp_if.sv]
interface dqe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [dqe_pkg::STS_W-1:0]           status;
   logic signed [dqe_pkg::VAL_W-1:0]    front_value;
   logic signed [dqe_pkg::VAL_W-1:0]    back_value;
   logic signed [dqe_pkg::VAL_W-1:0]    read_value;
   logic [dqe_pkg::CNT_W-1:0]           count;
   logic                                is_empty;

   modport source (output valid, status, front_value, back_value, read_value, count,
                   is_empty, input ready);
   modport sink   (input valid, status, front_value, back_value, read_value, count,
                   is_empty, output ready);
endinterface

[hw/rtl/circular_deque_engine.sv]
// Double-ended queue of up to DEPTH words kept in a circular single-port-write,
// registered-read memory. Each request transaction carries one opcode (push or
// pop at either end, indexed read, clear, resize) and returns exactly one
// response with status, front, back and indexed values, count and empty flag.
// The front and back words are cached in registers, so pushes, clear, failing
// operations and resizes that change nothing go from execute straight to done.
// Pops that leave words behind, an in-range indexed read and a shrinking resize
// to a nonzero target pass through a read wait state for the memory read port.
// A growing resize writes one pad word per cycle at the back. No reset sweep is
// needed: only entries inside the held range are ever read. A finished result
// sits in an output register, so the next request is accepted while it waits.
module circular_deque_engine #(
   parameter int DEPTH      = dqe_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dqe_req_if.sink   req,
   dqe_rsp_if.source rsp
);
   import dqe_pkg::*;

   localparam int PW = $clog2(DEPTH);

   logic                  wr_en;
   logic [PW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [PW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // Sequencer with pointers, cached end values and result register
   dqe_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Element storage
   dqe_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule

[hw/rtl/dqe_store.sv]
module dqe_store #(
   parameter int DEPTH      = dqe_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEFAULT,
   parameter int PW         = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [PW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/dqe_ctrl.sv]
module dqe_ctrl #(
   parameter int DEPTH      = dqe_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEFAULT,
   parameter int PW         = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   dqe_req_if.sink               req,
   dqe_rsp_if.source             rsp,
   output logic                  wr_en,
   output logic [PW-1:0]         wr_addr,
   output logic [DATA_WIDTH-1:0] wr_data,
   output logic                  rd_en,
   output logic [PW-1:0]         rd_addr,
   input  logic [DATA_WIDTH-1:0] rd_data
);
   import dqe_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = PW + 1;
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      return (p == '0) ? LAST_PTR : p - PW'(1);
   endfunction

   // Circular add of an offset known to be below DEPTH
   function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [PW-1:0] o);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(o);
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[PW-1:0];
   endfunction

   logic [2:0]            state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CW-1:0]         tgt_ff, tgt_in;
   logic                  sat_ff, sat_in;
   logic [PW-1:0]         head_ff, head_in;
   logic [PW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [DATA_WIDTH-1:0] rdv_ff, rdv_in;
   status_type            status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]      rsp_front_ff, rsp_front_in;
   logic [VAL_W-1:0]      rsp_back_ff, rsp_back_in;
   logic [VAL_W-1:0]      rsp_read_ff, rsp_read_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  out_free;
   logic                  accept;
   logic                  is_empty;
   logic [CW-1:0]         count_inc;
   logic [CW-1:0]         count_dec;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign accept    = req.valid && req.ready;
   assign is_empty  = (count_ff == '0);
   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);

   // Sequencer and deque bookkeeping
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      tgt_in        = tgt_ff;
      sat_in        = sat_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      rdv_in        = rdv_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = val_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      case (state_ff)
         S_IDLE: begin
         end
         S_EXEC: begin
            status_in = ST_OK;
            rdv_in    = '0;
            state_in  = S_DONE;
            case (op_ff)
               OP_PUSH_BACK: begin
                  if (count_ff == DEPTH_C) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     if (is_empty) begin
                        head_in  = '0;
                        tail_in  = '0;
                        wr_addr  = '0;
                        front_in = val_ff;
                     end else begin
                        tail_in = ptr_inc(tail_ff);
                        wr_addr = ptr_inc(tail_ff);
                     end
                     wr_en    = 1'b1;
                     back_in  = val_ff;
                     count_in = count_inc;
                  end
               end
               OP_PUSH_FRONT: begin
                  if (count_ff == DEPTH_C) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     if (is_empty) begin
                        head_in = '0;
                        tail_in = '0;
                        wr_addr = '0;
                        back_in = val_ff;
                     end else begin
                        head_in = ptr_dec(head_ff);
                        wr_addr = ptr_dec(head_ff);
                     end
                     wr_en    = 1'b1;
                     front_in = val_ff;
                     count_in = count_inc;
                  end
               end
               OP_POP_BACK: begin
                  if (is_empty) begin
                     status_in = ST_UNDERFLOW;
                  end else if (count_ff == CW'(1)) begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end else begin
                     tail_in  = ptr_dec(tail_ff);
                     count_in = count_dec;
                     rd_en    = 1'b1;
                     rd_addr  = ptr_dec(tail_ff);
                     state_in = S_RDWAIT;
                  end
               end
               OP_POP_FRONT: begin
                  if (is_empty) begin
                     status_in = ST_UNDERFLOW;
                  end else if (count_ff == CW'(1)) begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end else begin
                     head_in  = ptr_inc(head_ff);
                     count_in = count_dec;
                     rd_en    = 1'b1;
                     rd_addr  = ptr_inc(head_ff);
                     state_in = S_RDWAIT;
                  end
               end
               OP_READ_INDEX: begin
                  if (32'(pos_ff) >= 32'(count_ff)) begin
                     status_in = ST_RANGE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = ptr_add(head_ff, PW'(pos_ff));
                     state_in = S_RDWAIT;
                  end
               end
               OP_CLEAR: begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end
               OP_RESIZE: begin
                  status_in = sat_ff ? ST_OVERFLOW : ST_OK;
                  if (tgt_ff > count_ff) begin
                     state_in = S_FILL;
                  end else if (tgt_ff < count_ff) begin
                     if (tgt_ff == '0) begin
                        head_in  = '0;
                        tail_in  = '0;
                        count_in = '0;
                     end else begin
                        // Drop from the back: new tail sits target-1 past head
                        tail_in  = ptr_add(head_ff, PW'(tgt_ff - CW'(1)));
                        count_in = tgt_ff;
                        rd_en    = 1'b1;
                        rd_addr  = ptr_add(head_ff, PW'(tgt_ff - CW'(1)));
                        state_in = S_RDWAIT;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_RDWAIT: begin
            // Refresh the cached end value or capture the indexed word
            case (op_ff)
               OP_POP_BACK, OP_RESIZE: back_in = rd_data;
               OP_POP_FRONT:           front_in = rd_data;
               OP_READ_INDEX:          rdv_in = rd_data;
               default: begin
               end
            endcase
            state_in = S_DONE;
         end
         S_FILL: begin
            // One pad write per cycle at the back
            if (is_empty) begin
               head_in  = '0;
               tail_in  = '0;
               wr_addr  = '0;
               front_in = val_ff;
            end else begin
               tail_in = ptr_inc(tail_ff);
               wr_addr = ptr_inc(tail_ff);
            end
            wr_en    = 1'b1;
            back_in  = val_ff;
            count_in = count_inc;
            if (count_inc == tgt_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_front_in  = is_empty ? '0 : VAL_W'(front_ff);
               rsp_back_in   = is_empty ? '0 : VAL_W'(back_ff);
               rsp_read_in   = VAL_W'(rdv_ff);
               rsp_count_in  = CNT_W'(count_ff);
               rsp_empty_in  = is_empty;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // New transaction: capture operands, saturate the resize target
      if (accept) begin
         op_in    = req.opcode;
         val_in   = DATA_WIDTH'($unsigned(req.value));
         pos_in   = req.position;
         sat_in   = 32'(req.new_count) > 32'(DEPTH);
         tgt_in   = sat_in ? DEPTH_C : CW'(req.new_count);
         state_in = S_EXEC;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operand, cache and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      tgt_ff        <= tgt_in;
      sat_ff        <= sat_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      rdv_ff        <= rdv_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.front_value = rsp_front_ff;
   assign rsp.back_value  = rsp_back_ff;
   assign rsp.read_value  = rsp_read_ff;
   assign rsp.count       = rsp_count_ff;
   assign rsp.is_empty    = rsp_empty_ff;

   // An empty deque always has both pointers parked at zero
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty deque with nonzero pointers");

   // Fill count never passes the store depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> count_ff < DEPTH_C)
      else $error("pad write into a full store");

   // Store writes only come from push execution or resize padding
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXEC || state_ff == S_FILL))
      else $error("store write outside execute or fill");

   // The read wait state always follows an issued read
   a_rd_wait: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> state_ff == S_RDWAIT)
      else $error("read issued without a wait cycle");

   // An accepted transaction goes straight to execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted transaction not executed");
endmodule
